@@ src/mba_pkg.sv @@
// ---------------------------------------------------------------------------
// mba_pkg
// Shared types and codes for the mosaic block averaging block.
// ---------------------------------------------------------------------------
package mba_pkg;

    localparam int POS_W  = 12;
    localparam int SIZE_W = 7;
    localparam int CH_W   = 8;
    localparam int SUM_W  = 20;
    localparam int CFG_IW = 3;
    localparam int MIN_TILE = 4;

    localparam logic [CFG_IW-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_TOP    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_RIGHT  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BOTTOM = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_BSIZE  = 3'd4;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] alpha_in;
    } t_pix;

    typedef struct packed {
        logic [POS_W-1:0]  tile_left;
        logic [POS_W-1:0]  tile_top;
        logic [SIZE_W-1:0] tile_width;
        logic [SIZE_W-1:0] tile_height;
        logic [CH_W-1:0]   mean_red;
        logic [CH_W-1:0]   mean_green;
        logic [CH_W-1:0]   mean_blue;
        logic [CH_W-1:0]   mean_alpha;
        logic              region_done;
    } t_tile;

    typedef struct packed {
        logic accept;
        logic acc;
        logic div_start;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic tile_end;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ src/mba_div.sv @@
// ---------------------------------------------------------------------------
// mba_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mba_div #(
    parameter int NW = 20,
    parameter int DW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic          o_done
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_q, n_q;
    logic [DW-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [DW:0]      shifted, diff;

    always_comb begin
        shifted = {r_rem, r_q[NW-1]};
        diff    = shifted - {1'b0, i_den};
        n_q     = r_q;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = CNT_W'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // subtract when the shifted remainder covers the divisor
            if (shifted >= {1'b0, i_den}) begin
                n_rem = diff[DW-1:0];
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = shifted[DW-1:0];
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_quo  = r_q;
    assign o_done = r_done;
endmodule

@@ src/mba_ctrl.sv @@
// ---------------------------------------------------------------------------
// mba_ctrl
// Sequencer: accept, accumulate, divide, hand result to output register.
// ---------------------------------------------------------------------------
module mba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mba_pkg::t_sts i_sts,
    output logic          o_ready,
    output mba_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ACC    = 3'd1;
    localparam logic [2:0] S_LAUNCH = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid) n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_sts.tile_end ? S_LAUNCH : S_IDLE;
            end
            S_LAUNCH: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.load = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_ready = (r_state == S_IDLE);
endmodule

@@ src/mba_datapath.sv @@
// ---------------------------------------------------------------------------
// mba_datapath
// Registers, scan counters, column sum store, dividers and output register.
// ---------------------------------------------------------------------------
module mba_datapath #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_TILE  = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mba_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [mba_pkg::POS_W-1:0] i_cfg_data,
    input  mba_pkg::t_pix             i_pix,
    input  mba_pkg::t_cmd             i_cmd,
    output mba_pkg::t_sts             o_sts,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output mba_pkg::t_tile            o_tile
);
    localparam int PW    = mba_pkg::POS_W;
    localparam int ZW    = mba_pkg::SIZE_W;
    localparam int SW    = mba_pkg::SUM_W;
    localparam int CW    = mba_pkg::CH_W;
    localparam int DEPTH = MAX_WIDTH / mba_pkg::MIN_TILE;
    localparam int IW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_TILE * MAX_TILE + 1);
    localparam int OW    = $clog2(MAX_TILE);

    logic [PW-1:0] r_left, r_top, r_right, r_bottom;
    logic [ZW-1:0] r_bsize;
    logic [PW-1:0] r_x, r_y;
    logic [OW-1:0] r_row_in, r_col_in;
    logic [IW-1:0] r_idx;
    mba_pkg::t_pix r_pix;
    logic [4*SW-1:0] mem [DEPTH];
    logic [4*SW-1:0] r_rd, new_sum, r_sum;
    logic [NW-1:0] r_cnt;
    mba_pkg::t_tile r_tile, r_out, out_next;
    logic r_out_valid;

    logic [ZW-1:0] bs, tw, th;
    logic [PW-1:0] right, bottom, tile_x, tile_y;
    logic [PW:0]   tw_full, th_full;
    logic          first, tile_end;
    logic [CW-1:0] chan [4];
    logic [SW-1:0] quo [4];
    logic          done [4];
    logic [2*ZW-1:0] area;

    always_comb begin
        bs = r_bsize;
        if (r_bsize < ZW'(mba_pkg::MIN_TILE)) bs = ZW'(mba_pkg::MIN_TILE);
        else if (r_bsize > ZW'(MAX_TILE))     bs = ZW'(MAX_TILE);
        right  = (r_right < r_left) ? r_left : r_right;
        bottom = (r_bottom < r_top) ? r_top : r_bottom;
        tile_x = r_x - PW'(r_col_in);
        tile_y = r_y - PW'(r_row_in);
        tw_full = {1'b0, right} - {1'b0, tile_x} + 1'b1;
        th_full = {1'b0, bottom} - {1'b0, tile_y} + 1'b1;
        tw = (tw_full > (PW+1)'(bs)) ? bs : tw_full[ZW-1:0];
        th = (th_full > (PW+1)'(bs)) ? bs : th_full[ZW-1:0];
        tile_end = (ZW'(r_row_in) + 1'b1 == th) && (ZW'(r_col_in) + 1'b1 == tw);
        first = (r_row_in == '0) && (r_col_in == '0);
        area  = tw * th;
        chan[0] = r_pix.red_in;
        chan[1] = r_pix.green_in;
        chan[2] = r_pix.blue_in;
        chan[3] = r_pix.alpha_in;
        for (int c = 0; c < 4; c++) begin
            new_sum[c*SW +: SW] = first ? SW'(chan[c])
                                        : r_rd[c*SW +: SW] + SW'(chan[c]);
        end
    end

    // merge the tile geometry with the finished means
    always_comb begin
        out_next            = r_tile;
        out_next.mean_red   = quo[0][CW-1:0];
        out_next.mean_green = quo[1][CW-1:0];
        out_next.mean_blue  = quo[2][CW-1:0];
        out_next.mean_alpha = quo[3][CW-1:0];
    end

    // column sum store: read on accept, write back on accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_rd <= mem[r_idx];
        if (i_cmd.acc)    mem[r_idx] <= new_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_bsize  <= ZW'(mba_pkg::MIN_TILE);
            r_x      <= '0;
            r_y      <= '0;
            r_row_in <= '0;
            r_col_in <= '0;
            r_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx <= mba_pkg::CFG_BSIZE) begin
                unique case (i_cfg_idx)
                    mba_pkg::CFG_LEFT:   r_left   <= i_cfg_data;
                    mba_pkg::CFG_TOP:    r_top    <= i_cfg_data;
                    mba_pkg::CFG_RIGHT:  r_right  <= i_cfg_data;
                    mba_pkg::CFG_BOTTOM: r_bottom <= i_cfg_data;
                    default:             r_bsize  <= i_cfg_data[ZW-1:0];
                endcase
                // restart at the top left corner with fresh register values
                r_x <= (i_cfg_idx == mba_pkg::CFG_LEFT) ? i_cfg_data : r_left;
                r_y <= (i_cfg_idx == mba_pkg::CFG_TOP) ? i_cfg_data : r_top;
                r_row_in <= '0;
                r_col_in <= '0;
                r_idx    <= '0;
            end else if (i_cmd.acc) begin
                if (r_x >= right) begin
                    r_x      <= r_left;
                    r_col_in <= '0;
                    r_idx    <= '0;
                    if (r_y >= bottom) begin
                        r_y      <= r_top;
                        r_row_in <= '0;
                    end else begin
                        r_y      <= r_y + 1'b1;
                        r_row_in <= (ZW'(r_row_in) + 1'b1 >= bs) ? '0 : r_row_in + 1'b1;
                    end
                end else begin
                    r_x <= r_x + 1'b1;
                    if (ZW'(r_col_in) + 1'b1 >= bs) begin
                        r_col_in <= '0;
                        r_idx    <= (r_idx == IW'(DEPTH - 1)) ? '0 : r_idx + 1'b1;
                    end else begin
                        r_col_in <= r_col_in + 1'b1;
                    end
                end
            end
            if (i_cmd.load)         r_out_valid <= 1'b1;
            else if (i_out_ready)   r_out_valid <= 1'b0;
        end
        if (i_cmd.accept) r_pix <= i_pix;
        if (i_cmd.acc) begin
            r_sum <= new_sum;
            r_cnt <= NW'(area);
            r_tile.tile_left   <= tile_x;
            r_tile.tile_top    <= tile_y;
            r_tile.tile_width  <= tw;
            r_tile.tile_height <= th;
            r_tile.mean_red    <= '0;
            r_tile.mean_green  <= '0;
            r_tile.mean_blue   <= '0;
            r_tile.mean_alpha  <= '0;
            r_tile.region_done <= (r_x == right) && (r_y == bottom);
        end
        if (i_cmd.load) r_out <= out_next;
    end

    for (genvar c = 0; c < 4; c++) begin : g_div
        mba_div #(.NW(SW), .DW(NW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (i_cmd.div_start),
            .i_num   (r_sum[c*SW +: SW]),
            .i_den   (r_cnt),
            .o_quo   (quo[c]),
            .o_done  (done[c])
        );
    end

    assign o_sts.tile_end = tile_end;
    assign o_sts.div_done = done[0] & done[1] & done[2] & done[3];
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_tile         = r_out;
endmodule

@@ src/mosaic_block_average.sv @@
// ---------------------------------------------------------------------------
// mosaic_block_average
// Tile averaging for a mosaic filter over a configured image region.
// ---------------------------------------------------------------------------
// Send the region's pixels in raster order, one request per pixel. Each pixel
// passes through a column store read, then an add and write back; the pixel
// that closes a tile then goes on through the divider launch, twenty quotient
// steps and the done flag of the bit-serial mean dividers, and the load into
// the output register, which waits while the output register still holds an
// untaken result. Configuration writes restart the scan at the region's top
// left corner; write them only while no pixel is in progress.
// The column sum store needs no clearing: each entry is written by the first
// pixel of its tile.
module mosaic_block_average #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_TILE  = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mba_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [mba_pkg::POS_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  mba_pkg::t_pix              i_pix,
    output logic                       o_valid,
    input  logic                       i_ready,
    output mba_pkg::t_tile             o_tile
);
    mba_pkg::t_cmd cmd;
    mba_pkg::t_sts sts;

    // sequence each request through the datapath
    mba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    // hold region registers, scan position, sums and the result register
    mba_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_TILE(MAX_TILE)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_tile      (o_tile)
    );
endmodule

@@ src/mba_checker.sv @@
// ---------------------------------------------------------------------------
// mba_checker
// Port-level checks for the mosaic block averaging block.
// ---------------------------------------------------------------------------
module mba_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input mba_pkg::t_tile o_tile
);
    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tile))
        else $error("stalled result changed");

    // one request in flight at a time
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted back to back");

    // a tile has nonzero size
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_tile.tile_width != 0 && o_tile.tile_height != 0)
        else $error("empty tile");
endmodule

bind mosaic_block_average mba_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_tile  (o_tile)
);
